/* hw/rtl/gcoin_pkg.sv */
// ----------------------------------------------------------------------------
// gcoin_pkg
// Shared widths, register indexes and reset values for the greedy coin
// change unit.
// ----------------------------------------------------------------------------
package gcoin_pkg;

    localparam int AMT_W          = 16;
    localparam int DENOM_W        = 16;
    localparam int COUNT_W        = 16;
    localparam int SLOT_W         = 2;
    localparam int COINS_W        = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int NUM_DENOM_REGS = 4;
    localparam int BITS_PER_STAGE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COINS_IN_USE = 3'd0,
        CFG_DENOM_0      = 3'd1,
        CFG_DENOM_1      = 3'd2,
        CFG_DENOM_2      = 3'd3,
        CFG_DENOM_3      = 3'd4
    } cfg_reg_t;

    function automatic logic [DENOM_W-1:0] denom_reset(input int slot);
        logic [DENOM_W-1:0] value;
        case (slot)
            0:       value = DENOM_W'(25);
            1:       value = DENOM_W'(10);
            2:       value = DENOM_W'(5);
            default: value = DENOM_W'(1);
        endcase
        return value;
    endfunction

endpackage

/* hw/rtl/greedy_coin_change_unit.sv */
// ----------------------------------------------------------------------------
// greedy_coin_change_unit
// Greedy change maker: one amount in, one coin count per denomination out.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, amount): one transaction per amount.
// Output channel (out_valid, out_stall, coin_slot, coin_count, last,
// cannot_make): one transaction per denomination in use, slot 0 first;
// last marks the final one, and cannot_make is set on it when a nonzero
// remainder is left. Configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) is always ready; write it only while idle.
// Each denomination is divided by a restoring divider cut into
// ceil(min(AMOUNT_WIDTH,16)/2) stages of two quotient bits each, so the
// pipeline is NUM_COINS times that deep (32 stages at the defaults).
// The first result of an amount leaves after it has passed every stage and the serializer register.
// An amount enters every cycle while the pipeline has room; sustained rate
// is bounded by the output channel, which carries one count per cycle while
// out_stall is low, one count per denomination in use.
// Reset empties the pipeline, sets min(NUM_COINS,4) coins in use and loads 25, 10, 5, 1.
// While out_stall is high the current result holds, the pipeline fills up
// behind it, and in_stall rises once every stage is occupied.
// ----------------------------------------------------------------------------
module greedy_coin_change_unit #(
    parameter int NUM_COINS    = 4,
    parameter int AMOUNT_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [gcoin_pkg::AMT_W-1:0]           amount,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gcoin_pkg::SLOT_W-1:0]          coin_slot,
    output logic [gcoin_pkg::COUNT_W-1:0]         coin_count,
    output logic                                  last,
    output logic                                  cannot_make,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gcoin_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcoin_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import gcoin_pkg::*;

    localparam int REM_W         = (AMOUNT_WIDTH < AMT_W) ? AMOUNT_WIDTH : AMT_W;
    localparam int StagesPerCoin = (REM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int NumStages     = NUM_COINS * StagesPerCoin;
    localparam logic [COINS_W-1:0] CoinsReset =
        COINS_W'((NUM_COINS < NUM_DENOM_REGS) ? NUM_COINS : NUM_DENOM_REGS);
    localparam logic [COINS_W-1:0] CoinsMax = COINS_W'(NUM_COINS);

    typedef struct packed {
        logic [REM_W-1:0]                      rem;
        logic [DENOM_W-1:0]                    part;
        logic [REM_W-1:0]                      quot;
        logic [NUM_COINS-1:0][COUNT_W-1:0]     counts;
        logic                                  flag;
    } stage_t;

    logic [COINS_W-1:0] coins_in_use_reg;
    logic [COINS_W-1:0] coins_eff;
    logic [COINS_W-1:0] last_idx;
    logic [DENOM_W-1:0] denom [NUM_COINS];

    stage_t             stage_reg       [NumStages];
    stage_t             stage_next      [NumStages];
    logic               stage_valid_reg [NumStages];
    logic [NumStages:0] ready;

    logic [NUM_COINS-1:0][COUNT_W-1:0] ser_counts_reg, ser_counts_next;
    logic [COINS_W-1:0]                ser_slot_reg, ser_slot_next;
    logic                              ser_flag_reg, ser_flag_next;
    logic                              ser_valid_reg, ser_valid_next;
    logic                              ser_last;
    logic                              out_fire;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coins_in_use_reg <= CoinsReset;
        end
        else if (cfg_valid && cfg_index == CFG_COINS_IN_USE)
        begin
            coins_in_use_reg <= cfg_data[COINS_W-1:0];
        end
    end

    for (genvar k = 0; k < NUM_COINS; k++)
    begin : g_denom
        if (k < NUM_DENOM_REGS)
        begin : g_reg
            localparam logic [CFG_IDX_W-1:0] DenomIdx =
                CFG_IDX_W'(CFG_DENOM_0) + CFG_IDX_W'(k);
            logic [DENOM_W-1:0] denom_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    denom_reg <= denom_reset(k);
                end
                else if (cfg_valid && cfg_index == DenomIdx)
                begin
                    denom_reg <= cfg_data[DENOM_W-1:0];
                end
            end

            assign denom[k] = denom_reg;
        end
        else
        begin : g_fixed
            assign denom[k] = denom_reset(k);
        end
    end

    always_comb
    begin
        if (coins_in_use_reg == '0)
        begin
            coins_eff = COINS_W'(1);
        end
        else if (coins_in_use_reg > CoinsMax)
        begin
            coins_eff = CoinsMax;
        end
        else
        begin
            coins_eff = coins_in_use_reg;
        end
        last_idx = coins_eff - COINS_W'(1);
    end

    // ------------------------------------------------------------------
    // Divider pipeline
    // ------------------------------------------------------------------
    assign in_stall = !ready[0];

    for (genvar i = 0; i < NumStages; i++)
    begin : g_stage
        localparam int Coin = i / StagesPerCoin;
        localparam int Sub  = i % StagesPerCoin;

        stage_t src;
        logic   src_valid;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                src      = '0;
                src.rem  = amount[REM_W-1:0];
            end
            assign src_valid = in_valid;
        end
        else
        begin : g_next
            assign src       = stage_reg[i-1];
            assign src_valid = stage_valid_reg[i-1];
        end

        always_comb
        begin
            logic [DENOM_W:0]   trial;
            logic [DENOM_W-1:0] d;
            stage_next[i] = src;
            d             = denom[Coin];
            trial         = '0;
            for (int b = 0; b < BITS_PER_STAGE; b++)
            begin
                if (Sub * BITS_PER_STAGE + b < REM_W)
                begin
                    trial = {stage_next[i].part, stage_next[i].rem[REM_W-1]};
                    stage_next[i].rem = stage_next[i].rem << 1;
                    if (d != '0 && trial >= {1'b0, d})
                    begin
                        stage_next[i].part = DENOM_W'(trial - {1'b0, d});
                        stage_next[i].quot = {stage_next[i].quot[REM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        stage_next[i].part = trial[DENOM_W-1:0];
                        stage_next[i].quot = {stage_next[i].quot[REM_W-2:0], 1'b0};
                    end
                end
            end
            if (Sub == StagesPerCoin - 1)
            begin
                stage_next[i].counts[Coin] = COUNT_W'(stage_next[i].quot);
                if (COINS_W'(Coin) == last_idx)
                begin
                    stage_next[i].flag = (stage_next[i].part != '0);
                end
                stage_next[i].rem  = stage_next[i].part[REM_W-1:0];
                stage_next[i].part = '0;
                stage_next[i].quot = '0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[i] <= 1'b0;
            end
            else if (ready[i])
            begin
                stage_valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end

        assign ready[i] = !stage_valid_reg[i] || ready[i+1];
    end

    // ------------------------------------------------------------------
    // Result serializer
    // ------------------------------------------------------------------
    assign out_fire     = ser_valid_reg && !out_stall;
    assign ser_last     = (ser_slot_reg == last_idx);
    assign ready[NumStages] = !ser_valid_reg || (out_fire && ser_last);

    always_comb
    begin
        ser_counts_next = ser_counts_reg;
        ser_slot_next   = ser_slot_reg;
        ser_flag_next   = ser_flag_reg;
        ser_valid_next  = ser_valid_reg;
        if (ready[NumStages])
        begin
            ser_valid_next  = stage_valid_reg[NumStages-1];
            ser_counts_next = stage_reg[NumStages-1].counts;
            ser_flag_next   = stage_reg[NumStages-1].flag;
            ser_slot_next   = '0;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < NUM_COINS - 1; k++)
            begin
                ser_counts_next[k] = ser_counts_reg[k+1];
            end
            ser_slot_next = ser_slot_reg + COINS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_slot_reg  <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_slot_reg  <= ser_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_counts_reg <= ser_counts_next;
        ser_flag_reg   <= ser_flag_next;
    end

    assign out_valid   = ser_valid_reg;
    assign coin_slot   = ser_slot_reg[SLOT_W-1:0];
    assign coin_count  = ser_counts_reg[0];
    assign last        = ser_last;
    assign cannot_make = ser_last && ser_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> ser_slot_reg <= last_idx)
        else $error("result slot beyond last coin in use");

    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_valid_reg && !out_stall && !ser_last) |=>
            (ser_valid_reg && ser_slot_reg == $past(ser_slot_reg) + COINS_W'(1)))
        else $error("result sequence broken before last coin");

    a_input_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid_reg[0])
        else $error("accepted amount did not enter the pipeline");

endmodule
